>>> rtl/core/i2c_register_word_master_unit_assert.svh
// Assertion macros shared by the I2C word master RTL
`ifndef I2C_REGISTER_WORD_MASTER_UNIT_ASSERT_SVH
`define I2C_REGISTER_WORD_MASTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define I2CRW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("i2crw assertion failed");

// Next-cycle implication, checked out of reset
`define I2CRW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2crw assertion failed");

`endif

>>> rtl/core/i2crw_pkg.sv
// Types, constants and helper functions for the I2C word master
package i2crw_pkg;

	localparam int LINE_W    = 5;
	localparam int BUS_COUNT = 5;

	localparam logic [15:0] HALF_PERIOD_RST = 16'd40;
	localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd10;

	// Configuration register indexes
	localparam logic CFG_HALF_PERIOD = 1'b0;
	localparam logic CFG_ACK_TIMEOUT = 1'b1;

	// Request codes
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// Byte slots of a transfer
	localparam logic [2:0] SLOT_ADDR_W = 3'd0;
	localparam logic [2:0] SLOT_REG    = 3'd1;
	localparam logic [2:0] SLOT_THIRD  = 3'd2;
	localparam logic [2:0] SLOT_FOURTH = 3'd3;
	localparam logic [2:0] SLOT_DONE   = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START_HI,
		ST_START_LO,
		ST_TX_L,
		ST_TX_H,
		ST_ACK_L,
		ST_ACK_H,
		ST_POLL,
		ST_RS_L,
		ST_RX_L,
		ST_RX_H,
		ST_MA_L,
		ST_MA_H,
		ST_STOP_L,
		ST_STOP_H,
		ST_STOP_END
	} step_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [2:0]        bus;
		logic [6:0]        slave_addr;
		logic [7:0]        reg_addr;
		logic [15:0]       write_data;
		logic [LINE_W-1:0] sda_sense;
	} in_item_t;

	typedef struct packed {
		logic [LINE_W-1:0] scl_level;
		logic [LINE_W-1:0] sda_level;
		logic [LINE_W-1:0] sda_listen;
		logic              busy_res;
		logic              done_res;
		logic              ok;
		logic [15:0]       read_data;
	} out_item_t;

	// Byte sent in a given slot of the transfer
	function automatic logic [7:0] byte_for_slot(
		input logic [2:0]  slot,
		input logic        rd,
		input logic [6:0]  slave_addr,
		input logic [7:0]  reg_addr,
		input logic [15:0] data
	);
		logic [7:0] b;
		case (slot)
			SLOT_ADDR_W: b = {slave_addr, 1'b0};
			SLOT_REG:    b = reg_addr;
			SLOT_THIRD:  b = rd ? {slave_addr, 1'b1} : data[15:8];
			default:     b = data[7:0];
		endcase
		return b;
	endfunction

endpackage

>>> rtl/core/i2c_register_word_master_unit.sv
// I2C register word master: sequencer, configuration registers and result register
`include "i2c_register_word_master_unit_assert.svh"

// Five-bus I2C master for SMBus-style 16-bit register writes and reads. Every input
// item is one tick of bus time: the sequencer steps once per item and returns exactly
// one result item with the line levels after that tick, plus busy, done, ok and the
// word read. One item is taken per clock cycle while results are drained; the result
// appears in the output register in the next cycle. A new item is taken only when
// that register is empty or its result leaves in the same cycle, so a stall on the
// result side holds off the input. Bus timing (half_period ticks per SCL phase, up to
// ack_timeout+1 acknowledge polls) is counted in items, not cycles.
module i2c_register_word_master_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [15:0]            cfg_data,
	// items in
	input  logic                   in_valid,
	output logic                   in_ready,
	input  i2crw_pkg::in_item_t    in_data,
	// results out
	output logic                   out_valid,
	input  logic                   out_ready,
	output i2crw_pkg::out_item_t   out_data
);

	// configuration registers
	logic [15:0] half_period_q;
	logic [7:0]  ack_timeout_q;

	// sequencer state
	i2crw_pkg::step_t step_q, step_d;
	logic [15:0] ticks_q, ticks_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  poll_q, poll_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] word_q, word_d;
	logic [2:0]  slot_q, slot_d;
	logic        okf_q, okf_d;
	logic [1:0]  req_act_q, req_act_d;
	logic [2:0]  req_bus_q, req_bus_d;
	logic [6:0]  req_slave_q, req_slave_d;
	logic [7:0]  req_reg_q, req_reg_d;
	logic [15:0] req_data_q, req_data_d;

	// result register
	logic                 out_valid_q;
	i2crw_pkg::out_item_t out_q;
	i2crw_pkg::out_item_t res;

	logic                    in_fire;
	logic                    done;
	logic                    rd;
	logic                    start_req;
	logic                    sda;
	logic [15:0]             hp_eff;
	logic [16:0]             ticks_inc;
	logic [i2crw_pkg::LINE_W-1:0] cur_mask;
	logic [i2crw_pkg::LINE_W-1:0] new_mask;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign hp_eff    = (half_period_q == 16'd0) ? 16'd1 : half_period_q;
	assign ticks_inc = {1'b0, ticks_q} + 17'd1;
	assign rd        = (req_act_q == i2crw_pkg::ACT_READ);
	assign start_req = ((in_data.action == i2crw_pkg::ACT_WRITE) ||
		(in_data.action == i2crw_pkg::ACT_READ)) &&
		(32'(in_data.bus) < i2crw_pkg::BUS_COUNT);

	// bus select masks; a bus beyond the line bits selects nothing and reads SDA as 0
	always_comb begin
		for (int i = 0; i < i2crw_pkg::LINE_W; i++) begin
			cur_mask[i] = (32'(req_bus_q) == i);
			new_mask[i] = (32'(req_bus_d) == i);
		end
	end
	assign sda = |(in_data.sda_sense & cur_mask);

	// next state of the sequencer for one tick
	always_comb begin
		step_d      = step_q;
		ticks_d     = ticks_q;
		bit_d       = bit_q;
		poll_d      = poll_q;
		shift_d     = shift_q;
		word_d      = word_q;
		slot_d      = slot_q;
		okf_d       = okf_q;
		req_act_d   = req_act_q;
		req_bus_d   = req_bus_q;
		req_slave_d = req_slave_q;
		req_reg_d   = req_reg_q;
		req_data_d  = req_data_q;
		done        = 1'b0;
		if (step_q == i2crw_pkg::ST_IDLE) begin
			if (start_req) begin
				req_act_d   = in_data.action;
				req_bus_d   = in_data.bus;
				req_slave_d = in_data.slave_addr;
				req_reg_d   = in_data.reg_addr;
				req_data_d  = in_data.write_data;
				step_d      = i2crw_pkg::ST_START_HI;
				ticks_d     = '0;
				bit_d       = '0;
				poll_d      = '0;
				shift_d     = '0;
				word_d      = '0;
				slot_d      = i2crw_pkg::SLOT_ADDR_W;
				okf_d       = 1'b1;
			end
		end else if (step_q == i2crw_pkg::ST_POLL) begin
			ticks_d = '0;
			if (!sda) begin
				// acknowledged: move on to the next byte or phase
				if (!rd) begin
					if (slot_q >= i2crw_pkg::SLOT_FOURTH) begin
						okf_d  = 1'b1;
						step_d = i2crw_pkg::ST_STOP_L;
					end else begin
						slot_d  = slot_q + 3'd1;
						shift_d = i2crw_pkg::byte_for_slot(slot_q + 3'd1, rd,
							req_slave_q, req_reg_q, req_data_q);
						bit_d   = '0;
						step_d  = i2crw_pkg::ST_TX_L;
					end
				end else if (slot_q == i2crw_pkg::SLOT_ADDR_W) begin
					slot_d  = i2crw_pkg::SLOT_REG;
					shift_d = i2crw_pkg::byte_for_slot(i2crw_pkg::SLOT_REG, rd,
						req_slave_q, req_reg_q, req_data_q);
					bit_d   = '0;
					step_d  = i2crw_pkg::ST_TX_L;
				end else if (slot_q == i2crw_pkg::SLOT_REG) begin
					slot_d = i2crw_pkg::SLOT_THIRD;
					step_d = i2crw_pkg::ST_RS_L;
				end else begin
					slot_d  = i2crw_pkg::SLOT_FOURTH;
					bit_d   = '0;
					shift_d = '0;
					step_d  = i2crw_pkg::ST_RX_L;
				end
			end else if (poll_q >= ack_timeout_q) begin
				okf_d  = 1'b0;
				step_d = i2crw_pkg::ST_STOP_L;
			end else begin
				poll_d = poll_q + 8'd1;
			end
		end else begin
			ticks_d = ticks_inc[15:0];
			if (ticks_inc >= {1'b0, hp_eff}) begin
				ticks_d = '0;
				unique case (step_q)
					i2crw_pkg::ST_START_HI: step_d = i2crw_pkg::ST_START_LO;
					i2crw_pkg::ST_START_LO: begin
						shift_d = i2crw_pkg::byte_for_slot(slot_q, rd,
							req_slave_q, req_reg_q, req_data_q);
						bit_d   = '0;
						step_d  = i2crw_pkg::ST_TX_L;
					end
					i2crw_pkg::ST_TX_L: step_d = i2crw_pkg::ST_TX_H;
					i2crw_pkg::ST_TX_H: begin
						bit_d   = bit_q + 4'd1;
						shift_d = {shift_q[6:0], 1'b0};
						step_d  = (bit_q >= 4'd7) ? i2crw_pkg::ST_ACK_L : i2crw_pkg::ST_TX_L;
					end
					i2crw_pkg::ST_ACK_L: step_d = i2crw_pkg::ST_ACK_H;
					i2crw_pkg::ST_ACK_H: begin
						poll_d = '0;
						step_d = i2crw_pkg::ST_POLL;
					end
					i2crw_pkg::ST_RS_L: step_d = i2crw_pkg::ST_START_HI;
					i2crw_pkg::ST_RX_L: step_d = i2crw_pkg::ST_RX_H;
					i2crw_pkg::ST_RX_H: begin
						shift_d = {shift_q[6:0], sda};
						bit_d   = bit_q + 4'd1;
						if (bit_q >= 4'd7) begin
							word_d = {word_q[7:0], shift_q[6:0], sda};
							step_d = i2crw_pkg::ST_MA_L;
						end else begin
							step_d = i2crw_pkg::ST_RX_L;
						end
					end
					i2crw_pkg::ST_MA_L: step_d = i2crw_pkg::ST_MA_H;
					i2crw_pkg::ST_MA_H: begin
						if (slot_q == i2crw_pkg::SLOT_FOURTH) begin
							slot_d  = i2crw_pkg::SLOT_DONE;
							bit_d   = '0;
							shift_d = '0;
							step_d  = i2crw_pkg::ST_RX_L;
						end else begin
							okf_d  = 1'b1;
							step_d = i2crw_pkg::ST_STOP_L;
						end
					end
					i2crw_pkg::ST_STOP_L: step_d = i2crw_pkg::ST_STOP_H;
					i2crw_pkg::ST_STOP_H: step_d = i2crw_pkg::ST_STOP_END;
					i2crw_pkg::ST_STOP_END: begin
						step_d = i2crw_pkg::ST_IDLE;
						done   = 1'b1;
					end
					default: step_d = i2crw_pkg::ST_IDLE;
				endcase
			end
		end
	end

	// line levels and status after this tick
	always_comb begin
		logic c;
		logic d;
		logic l;
		c = 1'b1;
		d = 1'b1;
		l = 1'b0;
		unique case (step_d)
			i2crw_pkg::ST_START_LO: d = 1'b0;
			i2crw_pkg::ST_TX_L: begin
				c = 1'b0;
				d = shift_d[7];
			end
			i2crw_pkg::ST_TX_H: d = shift_d[7];
			i2crw_pkg::ST_ACK_L, i2crw_pkg::ST_RX_L: begin
				c = 1'b0;
				l = 1'b1;
			end
			i2crw_pkg::ST_ACK_H, i2crw_pkg::ST_POLL, i2crw_pkg::ST_RX_H: l = 1'b1;
			i2crw_pkg::ST_RS_L: c = 1'b0;
			i2crw_pkg::ST_MA_L: begin
				c = 1'b0;
				d = (slot_d != i2crw_pkg::SLOT_FOURTH);
			end
			i2crw_pkg::ST_MA_H: d = (slot_d != i2crw_pkg::SLOT_FOURTH);
			i2crw_pkg::ST_STOP_L: begin
				c = 1'b0;
				d = 1'b0;
			end
			i2crw_pkg::ST_STOP_H: d = 1'b0;
			default: ;
		endcase
		res.scl_level  = c ? '1 : ~new_mask;
		res.sda_level  = d ? '1 : ~new_mask;
		res.sda_listen = l ? new_mask : '0;
		res.busy_res   = (step_d != i2crw_pkg::ST_IDLE);
		res.done_res   = done;
		res.ok         = done && okf_d;
		res.read_data  = (done && okf_d && (req_act_d == i2crw_pkg::ACT_READ)) ? word_d : '0;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= i2crw_pkg::HALF_PERIOD_RST;
			ack_timeout_q <= i2crw_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				i2crw_pkg::CFG_HALF_PERIOD: half_period_q <= cfg_data;
				i2crw_pkg::CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer state, advanced once per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= i2crw_pkg::ST_IDLE;
			ticks_q     <= '0;
			bit_q       <= '0;
			poll_q      <= '0;
			shift_q     <= '0;
			word_q      <= '0;
			slot_q      <= i2crw_pkg::SLOT_ADDR_W;
			okf_q       <= 1'b1;
			req_act_q   <= i2crw_pkg::ACT_TICK;
			req_bus_q   <= '0;
			req_slave_q <= '0;
			req_reg_q   <= '0;
			req_data_q  <= '0;
		end else if (in_fire) begin
			step_q      <= step_d;
			ticks_q     <= ticks_d;
			bit_q       <= bit_d;
			poll_q      <= poll_d;
			shift_q     <= shift_d;
			word_q      <= word_d;
			slot_q      <= slot_d;
			okf_q       <= okf_d;
			req_act_q   <= req_act_d;
			req_bus_q   <= req_bus_d;
			req_slave_q <= req_slave_d;
			req_reg_q   <= req_reg_d;
			req_data_q  <= req_data_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_q <= res;
		end
	end

	// checks on the sequencer and result register
	`I2CRW_ASSERT_NOW(a_done_not_busy, clk, arst_n,
		out_valid_q && out_q.done_res, !out_q.busy_res)
	`I2CRW_ASSERT_NOW(a_data_only_on_done, clk, arst_n,
		out_valid_q && (out_q.read_data != 16'd0), out_q.done_res && out_q.ok)
	`I2CRW_ASSERT_NOW(a_one_bus_listens, clk, arst_n,
		out_valid_q, $onehot0(out_q.sda_listen))
	`I2CRW_ASSERT_NEXT(a_idle_after_done, clk, arst_n,
		in_fire && done, step_q == i2crw_pkg::ST_IDLE)

endmodule
